@@ src/prt_pkg.sv @@
// Package for the polyline ribbon tessellator.
// Holds the widths, the register indexes, the vertex kinds, the sequencer state type
// and the coordinate saturation. Used by polyline_ribbon_tessellator.
package prt_pkg;

    localparam int COORD_W   = 18;
    localparam int FRAC_BITS = 4;
    localparam int SAMPLE_W  = 16;
    localparam int VIEW_W    = 12;
    localparam int COUNT_W   = 13;
    localparam int INDEX_W   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int MUL_W     = 18;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int NUM_W     = 40;
    localparam int SRC_W     = 54;
    localparam int ACC_W     = 32;
    localparam int ROOT_W    = 27;
    localparam int ITER_W    = 6;
    localparam int OFS_W     = 24;

    localparam logic [ITER_W-1:0] DIV_ITERS  = ITER_W'(NUM_W);
    localparam logic [ITER_W-1:0] ROOT_ITERS = ITER_W'(ROOT_W);

    localparam logic signed [OFS_W-1:0] CMAX = OFS_W'(131071);
    localparam logic signed [OFS_W-1:0] CMIN = -OFS_W'(131072);

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_H    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STROKE_W  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_EN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 3'd6;

    localparam logic [1:0] KIND_FILL_TOP  = 2'd0;
    localparam logic [1:0] KIND_FILL_BASE = 2'd1;
    localparam logic [1:0] KIND_STROKE_P  = 2'd2;
    localparam logic [1:0] KIND_STROKE_M  = 2'd3;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_YMUL  = 14'b00000000000010,
        ST_YDIV  = 14'b00000000000100,
        ST_XMUL  = 14'b00000000001000,
        ST_XDIV  = 14'b00000000010000,
        ST_PSEL  = 14'b00000000100000,
        ST_SQX   = 14'b00000001000000,
        ST_SQY   = 14'b00000010000000,
        ST_ROOT  = 14'b00000100000000,
        ST_OXMUL = 14'b00001000000000,
        ST_OXDIV = 14'b00010000000000,
        ST_OYMUL = 14'b00100000000000,
        ST_OYDIV = 14'b01000000000000,
        ST_EMIT  = 14'b10000000000000
    } t_state;

    // clip a wide signed coordinate to the 18 bit range
    function automatic logic signed [COORD_W-1:0] sat18(input logic signed [OFS_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > CMAX) begin
            r = COORD_W'(CMAX);
        end else if (v < CMIN) begin
            r = COORD_W'(CMIN);
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ src/polyline_ribbon_tessellator.sv @@
// Top level of the polyline ribbon tessellator: sample mapping, stroke normals, vertex output.
// Depends on prt_pkg for widths, codes, the state type and coordinate saturation.
//
// Channel   Dir  Handshake                         Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   tdata[15:0] sample_value
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   tdata x,y; tuser kind; tlast run_last
// cfg       in   i_cfg_we                          i_cfg_idx register, i_cfg_data value
//
// Input: one word at a time. After acceptance the input ready stays low until the sequencer
// is back in idle: shortest on the first sample of a frame, longer on a mid-frame sample (one
// point) and longest on the last sample of a frame (two points), more with fill, plus any output
// stall. This is set by the shared radix-2 divide / square-root unit and the single registered
// 18x18 multiplier, used in turn under the sequencer.
// Reset: synchronous, active low; clears the sequencer, the frame index, the stored points, the
// output valid flag and loads the configuration defaults. Output stalls hold the sequencer.

module polyline_ribbon_tessellator
    import prt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,   // [15:0] sample_value
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [39:0]          o_m_axis_tdata,   // [17:0] vertex_x, [35:18] vertex_y, pad
    output logic [1:0]           o_m_axis_tuser,   // [1:0] vertex_kind
    output logic                 o_m_axis_tlast,   // run_last
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // configuration
    logic signed [SAMPLE_W-1:0] r_rmin, r_rmax;
    logic [VIEW_W-1:0]          r_vw, r_vh, r_sw;
    logic                       r_fill;
    logic [COUNT_W-1:0]         r_cnt;

    // sequencer and frame state
    t_state                     r_st;
    logic [INDEX_W-1:0]         r_idx;
    logic signed [COORD_W-1:0]  r_prev_x, r_prev_y, r_old_x, r_old_y;
    logic signed [COORD_W-1:0]  r_cx, r_cy, r_px, r_py;
    logic signed [COORD_W:0]    r_dx, r_dy;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_pt;
    logic [1:0]                 r_vk;
    logic signed [OFS_W-1:0]    r_ox, r_oy;

    // multiplier and shared divide / root unit
    logic [PROD_W-1:0]          r_prod;
    logic [PROD_W+1:0]          r_s;
    logic [ROOT_W-1:0]          r_root;
    logic [SRC_W-1:0]           r_src;
    logic [ACC_W-1:0]           r_acc, r_den;
    logic [NUM_W-1:0]           r_q;
    logic [ITER_W-1:0]          r_iter;
    logic                       r_ld, r_sqrt;

    // output word
    logic                       r_ov, r_olast;
    logic signed [COORD_W-1:0]  r_ox_out, r_oy_out;
    logic [1:0]                 r_okind;

    assign o_s_axis_tready = (r_st == ST_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {4'b0000, r_oy_out, r_ox_out};
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tlast  = r_olast;

    // ---- sample mapping terms, from the held sample and the static configuration ----
    logic signed [SAMPLE_W-1:0] v_hi, v_cl;
    logic signed [SAMPLE_W:0]   num_s, span_s;
    logic [SAMPLE_W-1:0]        num_u, span_eff;
    logic [SAMPLE_W-1:0]        hf;
    logic [COUNT_W-1:0]         cnt_c;
    logic [INDEX_W-1:0]         cntm1;
    logic                       last_item;

    always_comb begin
        v_hi   = (r_sample > r_rmax) ? r_rmax : r_sample;
        v_cl   = (v_hi < r_rmin) ? r_rmin : v_hi;
        num_s  = (SAMPLE_W+1)'(v_cl) - (SAMPLE_W+1)'(r_rmin);
        num_u  = num_s[SAMPLE_W-1:0];
        span_s = (SAMPLE_W+1)'(r_rmax) - (SAMPLE_W+1)'(r_rmin);
        // a flat or inverted range divides by one; the sample then sits at zero anyway
        span_eff = (span_s <= 0) ? SAMPLE_W'(1) : span_s[SAMPLE_W-1:0];
        hf     = {r_vh, {FRAC_BITS{1'b0}}};
        if (r_cnt < COUNT_W'(2)) begin
            cnt_c = COUNT_W'(2);
        end else if (r_cnt > COUNT_W'(4096)) begin
            cnt_c = COUNT_W'(4096);
        end else begin
            cnt_c = r_cnt;
        end
        cntm1     = INDEX_W'(cnt_c - COUNT_W'(1));
        last_item = (r_idx >= cntm1);
    end

    // ---- magnitudes for the multiplier ----
    logic signed [COORD_W:0] ndx, ndy;
    logic [MUL_W-1:0]        adx, ady, mul_a, mul_b;

    always_comb begin
        ndx = -r_dx;
        ndy = -r_dy;
        adx = r_dx[COORD_W] ? ndx[MUL_W-1:0] : r_dx[MUL_W-1:0];
        ady = r_dy[COORD_W] ? ndy[MUL_W-1:0] : r_dy[MUL_W-1:0];
        case (r_st)
            ST_YMUL: begin
                mul_a = MUL_W'(num_u);
                mul_b = MUL_W'(hf);
            end
            ST_XMUL: begin
                mul_a = MUL_W'(r_idx);
                mul_b = MUL_W'(r_vw);
            end
            ST_SQX: begin
                mul_a = adx;
                mul_b = adx;
            end
            ST_SQY: begin
                mul_a = ady;
                mul_b = ady;
            end
            ST_OXMUL: begin
                mul_a = ady;
                mul_b = MUL_W'(r_sw);
            end
            ST_OYMUL: begin
                mul_a = adx;
                mul_b = MUL_W'(r_sw);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---- shared unit: one restoring divide bit or one root digit a cycle ----
    logic [ACC_W-1:0] sh_acc, oper;
    logic [ACC_W:0]   diff;
    logic             ge;

    always_comb begin
        if (r_sqrt) begin
            sh_acc = {r_acc[ACC_W-3:0], r_src[SRC_W-1:SRC_W-2]};
            oper   = {r_q[ACC_W-3:0], 2'b01};
        end else begin
            sh_acc = {r_acc[ACC_W-2:0], r_src[SRC_W-1]};
            oper   = r_den;
        end
        diff = {1'b0, sh_acc} - {1'b0, oper};
        ge   = ~diff[ACC_W];
    end

    // operand loads for the unit; a rounded divide runs as (2m + d) / (2d)
    logic [ACC_W-1:0] den_y, den_x, den_o;
    logic [NUM_W-1:0] nsum_y, nsum_x, nsum_o;
    logic [PROD_W+1:0] s_sum;

    always_comb begin
        den_y  = ACC_W'({span_eff, 1'b0});
        den_x  = ACC_W'({cntm1, 1'b0});
        den_o  = ACC_W'({r_root, 1'b0});
        nsum_y = (NUM_W'(r_prod) << 1) + NUM_W'(span_eff);
        nsum_x = (NUM_W'(r_prod) << (FRAC_BITS + 1)) + NUM_W'(cntm1);
        nsum_o = (NUM_W'(r_prod) << 8) + NUM_W'(r_root);
        s_sum  = r_s + (PROD_W+2)'(r_prod);
    end

    // ---- point selection and vertex values ----
    logic signed [COORD_W-1:0] sel_px, sel_py, sel_bx, sel_by;
    logic signed [COORD_W:0]   sel_dx, sel_dy;
    logic signed [OFS_W-1:0]   q_pos, q_neg;
    logic signed [COORD_W-1:0] vx, vy;
    logic                      slot_free, pt_final;

    always_comb begin
        if (r_pt) begin
            sel_px = r_cx;
            sel_py = r_cy;
            sel_bx = r_prev_x;
            sel_by = r_prev_y;
        end else begin
            sel_px = r_prev_x;
            sel_py = r_prev_y;
            sel_bx = (r_idx == INDEX_W'(1)) ? r_prev_x : r_old_x;
            sel_by = (r_idx == INDEX_W'(1)) ? r_prev_y : r_old_y;
        end
        sel_dx = (COORD_W+1)'(r_cx) - (COORD_W+1)'(sel_bx);
        sel_dy = (COORD_W+1)'(r_cy) - (COORD_W+1)'(sel_by);
        if (r_pt) begin
            sel_dx = (COORD_W+1)'(r_cx) - (COORD_W+1)'(r_prev_x);
            sel_dy = (COORD_W+1)'(r_cy) - (COORD_W+1)'(r_prev_y);
        end

        q_pos = OFS_W'(r_q[19:0]);
        q_neg = -q_pos;

        case (r_vk)
            KIND_FILL_TOP: begin
                vx = r_px;
                vy = r_py;
            end
            KIND_FILL_BASE: begin
                vx = r_px;
                vy = COORD_W'(hf);
            end
            KIND_STROKE_P: begin
                vx = sat18(OFS_W'(r_px) + r_ox);
                vy = sat18(OFS_W'(r_py) + r_oy);
            end
            default: begin
                vx = sat18(OFS_W'(r_px) - r_ox);
                vy = sat18(OFS_W'(r_py) - r_oy);
            end
        endcase

        slot_free = ~r_ov | i_m_axis_tready;
        pt_final  = r_pt | ~last_item;
    end

    // ---- configuration writes ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmin <= -16'sd32768;
            r_rmax <= 16'sd32767;
            r_vw   <= VIEW_W'(640);
            r_vh   <= VIEW_W'(480);
            r_sw   <= VIEW_W'(16);
            r_fill <= 1'b0;
            r_cnt  <= COUNT_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RANGE_MIN: r_rmin <= i_cfg_data;
                REG_RANGE_MAX: r_rmax <= i_cfg_data;
                REG_VIEW_W:    r_vw   <= i_cfg_data[VIEW_W-1:0];
                REG_VIEW_H:    r_vh   <= i_cfg_data[VIEW_W-1:0];
                REG_STROKE_W:  r_sw   <= i_cfg_data[VIEW_W-1:0];
                REG_FILL_EN:   r_fill <= i_cfg_data[0];
                REG_COUNT:     r_cnt  <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- multiplier, always registered ----
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // ---- sequencer ----
    logic unit_done;
    assign unit_done = ~r_ld & (r_iter == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_idx    <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_old_x  <= '0;
            r_old_y  <= '0;
            r_ov     <= 1'b0;
            r_ld     <= 1'b0;
            r_iter   <= '0;
        end else begin
            // drain the output word when taken; the emit state refills it itself
            if (r_ov && i_m_axis_tready && r_st != ST_EMIT) begin
                r_ov <= 1'b0;
            end

            // advance the shared unit
            if (r_ld) begin
                r_ld <= 1'b0;
            end else if (r_iter != '0) begin
                r_acc  <= ge ? diff[ACC_W-1:0] : sh_acc;
                r_q    <= {r_q[NUM_W-2:0], ge};
                r_src  <= r_sqrt ? (r_src << 2) : (r_src << 1);
                r_iter <= r_iter - ITER_W'(1);
            end

            case (r_st)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_sample <= i_s_axis_tdata;
                        r_st     <= ST_YMUL;
                    end
                end
                ST_YMUL: begin
                    r_ld <= 1'b1;
                    r_st <= ST_YDIV;
                end
                ST_YDIV: begin
                    if (r_ld) begin
                        r_src  <= {nsum_y, {(SRC_W-NUM_W){1'b0}}};
                        r_den  <= den_y;
                        r_acc  <= '0;
                        r_q    <= '0;
                        r_sqrt <= 1'b0;
                        r_iter <= DIV_ITERS;
                    end else if (unit_done) begin
                        r_cy <= COORD_W'({2'b00, hf}) - r_q[COORD_W-1:0];
                        r_st <= ST_XMUL;
                    end
                end
                ST_XMUL: begin
                    r_ld <= 1'b1;
                    r_st <= ST_XDIV;
                end
                ST_XDIV: begin
                    if (r_ld) begin
                        r_src  <= {nsum_x, {(SRC_W-NUM_W){1'b0}}};
                        r_den  <= den_x;
                        r_acc  <= '0;
                        r_q    <= '0;
                        r_sqrt <= 1'b0;
                        r_iter <= DIV_ITERS;
                    end else if (unit_done) begin
                        r_cx <= (r_q > NUM_W'(CMAX)) ? COORD_W'(CMAX) : r_q[COORD_W-1:0];
                        if (r_idx == '0) begin
                            // first sample of a frame: store the point, emit nothing
                            r_prev_x <= (r_q > NUM_W'(CMAX)) ? COORD_W'(CMAX)
                                                            : r_q[COORD_W-1:0];
                            r_prev_y <= r_cy;
                            r_idx    <= INDEX_W'(1);
                            r_st     <= ST_IDLE;
                        end else begin
                            r_pt <= 1'b0;
                            r_st <= ST_PSEL;
                        end
                    end
                end
                ST_PSEL: begin
                    r_px <= sel_px;
                    r_py <= sel_py;
                    // a zero direction stands for (1,0)
                    if (sel_dx == '0 && sel_dy == '0) begin
                        r_dx <= (COORD_W+1)'(1);
                        r_dy <= '0;
                    end else begin
                        r_dx <= sel_dx;
                        r_dy <= sel_dy;
                    end
                    r_st <= ST_SQX;
                end
                ST_SQX: begin
                    r_st <= ST_SQY;
                end
                ST_SQY: begin
                    r_s  <= (PROD_W+2)'(r_prod);
                    r_ld <= 1'b1;
                    r_st <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (r_ld) begin
                        r_src  <= {s_sum, 16'h0000};
                        r_acc  <= '0;
                        r_q    <= '0;
                        r_sqrt <= 1'b1;
                        r_iter <= ROOT_ITERS;
                    end else if (unit_done) begin
                        r_root <= r_q[ROOT_W-1:0];
                        r_st   <= ST_OXMUL;
                    end
                end
                ST_OXMUL: begin
                    r_ld <= 1'b1;
                    r_st <= ST_OXDIV;
                end
                ST_OXDIV: begin
                    if (r_ld) begin
                        r_src  <= {nsum_o, {(SRC_W-NUM_W){1'b0}}};
                        r_den  <= den_o;
                        r_acc  <= '0;
                        r_q    <= '0;
                        r_sqrt <= 1'b0;
                        r_iter <= DIV_ITERS;
                    end else if (unit_done) begin
                        // normal x runs along -dy
                        r_ox <= (r_dy > 0) ? q_neg : q_pos;
                        r_st <= ST_OYMUL;
                    end
                end
                ST_OYMUL: begin
                    r_ld <= 1'b1;
                    r_st <= ST_OYDIV;
                end
                ST_OYDIV: begin
                    if (r_ld) begin
                        r_src  <= {nsum_o, {(SRC_W-NUM_W){1'b0}}};
                        r_den  <= den_o;
                        r_acc  <= '0;
                        r_q    <= '0;
                        r_sqrt <= 1'b0;
                        r_iter <= DIV_ITERS;
                    end else if (unit_done) begin
                        r_oy <= (r_dx < 0) ? q_neg : q_pos;
                        r_vk <= r_fill ? KIND_FILL_TOP : KIND_STROKE_P;
                        r_st <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        r_ov     <= 1'b1;
                        r_ox_out <= vx;
                        r_oy_out <= vy;
                        r_okind  <= r_vk;
                        r_olast  <= (r_vk == KIND_STROKE_M) && pt_final;
                        r_vk     <= r_vk + 2'd1;
                        if (r_vk == KIND_STROKE_M) begin
                            if (!pt_final) begin
                                r_pt <= 1'b1;
                                r_st <= ST_PSEL;
                            end else begin
                                // shift the point history and step the frame index
                                r_old_x  <= r_prev_x;
                                r_old_y  <= r_prev_y;
                                r_prev_x <= r_cx;
                                r_prev_y <= r_cy;
                                r_idx    <= last_item ? '0 : r_idx + INDEX_W'(1);
                                r_st     <= ST_IDLE;
                            end
                        end
                    end else if (r_ov && i_m_axis_tready) begin
                        r_ov <= 1'b0;
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for polyline_ribbon_tessellator: directed table, then random frames.
// Predicts each stroke and fill vertex from the sample stream and register settings.
// Depends on prt_pkg and src/polyline_ribbon_tessellator.sv.
`timescale 1ns / 100ps

module tb_top;
    import prt_pkg::*;

    localparam int  HALF_PERIOD = 6;
    localparam int  SETTLE      = 400;     // cycles after the last vertex before a register write
    localparam int  RAND_ITEMS  = 450;
    localparam int  LONG_HOLD   = 3000;

    typedef enum logic [1:0] { ROW_CFG, ROW_SAMPLE } t_row_op;

    typedef struct {
        t_row_op          op;
        logic [2:0]       idx;
        logic [15:0]      val;
        int               ntyped;   // >= 0: vertices typed below; -1: use predictor
    } t_row;

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic [1:0]         kind;
        logic               last;
    } t_vertex;

    // clock and ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;    // [15:0] sample_value
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;         // [17:0] vertex_x, [35:18] vertex_y, pad
    logic [1:0]  o_m_axis_tuser;         // [1:0] vertex_kind
    logic        o_m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    polyline_ribbon_tessellator DUT (.*);

    // mirror of the block's registers and trace state
    longint rng_min, rng_max, view_w, view_h, stroke_w, fill_on, frame_len;
    longint next_idx, p1_x, p1_y, p2_x, p2_y;

    t_vertex vertex_q[$];
    int      fail_cnt = 0;
    int      samples_sent = 0;
    int      vertices_seen = 0;
    int      phases_run = 0;

    // ---------------------------------------------------------------- arithmetic
    function automatic longint round_div(longint num, longint den);
        longint m, q;
        m = (num < 0) ? -num : num;
        q = (2 * m + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint clip18(longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    function automatic void push_vertex(longint x, longint y, logic [1:0] kind);
        t_vertex e;
        e.x = 18'(clip18(x));
        e.y = 18'(clip18(y));
        e.kind = kind;
        e.last = 1'b0;
        vertex_q.push_back(e);
    endfunction

    // fill pair (optional) then the two stroke edges of one trace point
    function automatic void push_point(longint px, longint py, longint dx, longint dy);
        longint swf, ox, oy, r;
        swf = stroke_w << FRAC_BITS;
        if (fill_on != 0) begin
            push_vertex(px, py, KIND_FILL_TOP);
            push_vertex(px, view_h << FRAC_BITS, KIND_FILL_BASE);
        end
        if (dx == 0 && dy == 0) begin
            // degenerate direction: stroke runs along +x
            ox = 0;
            oy = round_div(swf, 32);
        end else begin
            r  = int_sqrt(longint'(dx * dx + dy * dy) << 16);
            ox = round_div(-dy * swf * 256, 32 * r);
            oy = round_div(dx * swf * 256, 32 * r);
        end
        push_vertex(px + ox, py + oy, KIND_STROKE_P);
        push_vertex(px - ox, py - oy, KIND_STROKE_M);
    endfunction

    // advance the trace by one accepted sample; push_out=0 only updates the state
    function automatic void predict_vertices(logic [15:0] raw, bit push_out);
        longint cnt, v, span, term, cx, cy, bx, by, i, hf;
        bit     at_end;
        cnt = frame_len;
        if (cnt < 2) cnt = 2;
        if (cnt > 4096) cnt = 4096;
        i  = next_idx & 12'hFFF;
        hf = view_h << FRAC_BITS;
        v  = longint'($signed(raw));
        if (v > rng_max) v = rng_max;
        if (v < rng_min) v = rng_min;
        span = rng_max - rng_min;
        if (span == 0) span = 1;
        term = (span > 0) ? round_div((v - rng_min) * hf, span) : 0;
        cx = clip18(round_div(i * view_w * 16, cnt - 1));
        cy = clip18(hf - term);
        if (i == 0) begin
            p1_x = cx;
            p1_y = cy;
            next_idx = 1;
            return;
        end
        at_end = (i >= cnt - 1);
        bx = (i == 1) ? p1_x : p2_x;
        by = (i == 1) ? p1_y : p2_y;
        if (push_out) begin
            push_point(p1_x, p1_y, cx - bx, cy - by);
            if (at_end) push_point(cx, cy, cx - p1_x, cy - p1_y);
            vertex_q[vertex_q.size() - 1].last = 1'b1;
        end
        p2_x = p1_x;
        p2_y = p1_y;
        p1_x = cx;
        p1_y = cy;
        next_idx = at_end ? 0 : ((i + 1) & 12'hFFF);
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic wait_idle();
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_RANGE_MIN: rng_min   = longint'($signed(val));
            REG_RANGE_MAX: rng_max   = longint'($signed(val));
            REG_VIEW_W:    view_w    = val[11:0];
            REG_VIEW_H:    view_h    = val[11:0];
            REG_STROKE_W:  stroke_w  = val[11:0];
            REG_FILL_EN:   fill_on   = val[0];
            REG_COUNT:     frame_len = val[12:0];
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(4, 1);
        return $urandom_range(80, 20);
    endfunction

    // offer one word; hold tvalid high across back-to-back words
    task automatic send_sample(logic [15:0] v, bit use_pred);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= v;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_vertices(v, use_pred);
        samples_sent++;
    endtask

    task automatic end_burst();
        i_s_axis_tvalid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- receiver
    int rx_words = 0;
    initial begin
        int stall;
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && rx_words >= 300) begin
                // long back-pressure: the block fills and drops its input ready
                held = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = $urandom_range(99);
            stall = (stall < 65) ? 0 : (stall < 95) ? $urandom_range(3, 1)
                                                    : $urandom_range(60, 20);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            rx_words++;
            vertices_seen++;
            if (vertex_q.size() == 0) begin
                $error("unexpected vertex x=%0d y=%0d kind=%0d",
                       $signed(o_m_axis_tdata[17:0]), $signed(o_m_axis_tdata[35:18]),
                       o_m_axis_tuser);
                fail_cnt++;
            end else begin
                e = vertex_q.pop_front();
                if (o_m_axis_tdata[17:0] !== e.x) begin
                    $error("vertex_x expected %0d got %0d", e.x,
                           $signed(o_m_axis_tdata[17:0]));
                    fail_cnt++;
                end
                if (o_m_axis_tdata[35:18] !== e.y) begin
                    $error("vertex_y expected %0d got %0d", e.y,
                           $signed(o_m_axis_tdata[35:18]));
                    fail_cnt++;
                end
                if (o_m_axis_tuser !== e.kind) begin
                    $error("vertex_kind expected %0d got %0d", e.kind, o_m_axis_tuser);
                    fail_cnt++;
                end
                if (o_m_axis_tlast !== e.last) begin
                    $error("run_last expected %0d got %0d", e.last, o_m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- directed table
    // Typed rows: reset defaults give a flat 2-point frame 640 px wide at the bottom edge,
    // stroke 1 px so +/-0.5 px (8 LSB) in y.
    t_row dir_rows[] = '{
        '{ROW_SAMPLE, 3'd0, 16'h8000,  0},          // first sample of frame: nothing
        '{ROW_SAMPLE, 3'd0, 16'h8000,  4},          // full-scale min, both ends
        '{ROW_CFG,    REG_VIEW_W, 16'd0, -1},       // zero width: direction collapses
        '{ROW_SAMPLE, 3'd0, 16'h8000,  0},
        '{ROW_SAMPLE, 3'd0, 16'h8000,  4},
        '{ROW_CFG,    REG_VIEW_W, 16'd640, -1},
        '{ROW_CFG,    REG_RANGE_MIN, 16'd100, -1},  // inverted range: every sample at min
        '{ROW_CFG,    REG_RANGE_MAX, 16'hFF9C, -1},
        '{ROW_SAMPLE, 3'd0, 16'h7FFF,  0},
        '{ROW_SAMPLE, 3'd0, 16'h1234,  4},
        '{ROW_CFG,    REG_RANGE_MIN, 16'hFF9C, -1}, // clamp window -100..100
        '{ROW_CFG,    REG_RANGE_MAX, 16'd100, -1},
        '{ROW_CFG,    REG_FILL_EN,   16'd1, -1},
        '{ROW_CFG,    REG_STROKE_W,  16'd4095, -1},
        '{ROW_CFG,    REG_COUNT,     16'd5, -1},
        '{ROW_SAMPLE, 3'd0, 16'h7FFF, -1},
        '{ROW_SAMPLE, 3'd0, 16'h8000, -1},
        '{ROW_SAMPLE, 3'd0, 16'h0000, -1},
        '{ROW_SAMPLE, 3'd0, 16'h0032, -1},
        '{ROW_SAMPLE, 3'd0, 16'hFFFF, -1},
        '{ROW_CFG,    REG_COUNT,     16'h1FFF, -1}, // oversize count saturates
        '{ROW_CFG,    REG_VIEW_W,    16'd4095, -1},
        '{ROW_CFG,    REG_VIEW_H,    16'd4095, -1},
        '{ROW_SAMPLE, 3'd0, 16'h0001, -1},
        '{ROW_SAMPLE, 3'd0, 16'h0064, -1},
        '{ROW_SAMPLE, 3'd0, 16'hFF00, -1},
        '{ROW_CFG,    REG_COUNT,     16'd0, -1},    // shrink mid frame, below two
        '{ROW_SAMPLE, 3'd0, 16'h0010, -1},
        '{ROW_CFG,    REG_VIEW_H,    16'd0, -1},
        '{ROW_CFG,    REG_STROKE_W,  16'd0, -1},
        '{ROW_SAMPLE, 3'd0, 16'h0050, -1},
        '{ROW_SAMPLE, 3'd0, 16'hFFB0, -1}
    };

    t_vertex flat_frame[4] = '{
        '{18'sd0,     18'sd7688, KIND_STROKE_P, 1'b0},
        '{18'sd0,     18'sd7672, KIND_STROKE_M, 1'b0},
        '{18'sd10240, 18'sd7688, KIND_STROKE_P, 1'b0},
        '{18'sd10240, 18'sd7672, KIND_STROKE_M, 1'b1}
    };

    // ---------------------------------------------------------------- main sequence
    initial begin
        t_row    row;
        t_vertex tv;
        int      rand_done, flen, k;
        longint  lo_v;

        rng_min = -32768; rng_max = 32767; view_w = 640; view_h = 480;
        stroke_w = 16; fill_on = 0; frame_len = 2;
        next_idx = 0; p1_x = 0; p1_y = 0; p2_x = 0; p2_y = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the table; config rows wait for the block to go quiet
        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.op == ROW_CFG) begin
                end_burst();
                wait_idle();
                write_reg(row.idx, row.val);
            end else begin
                send_sample(row.val, row.ntyped < 0);
                for (k = 0; k < row.ntyped; k++) begin
                    tv = flat_frame[k];
                    if (k == 0) begin
                        // the zero-width frame puts both points at x = 0
                        if (view_w == 0) tv.x = 0;
                    end else if (view_w == 0) begin
                        tv.x = 0;
                    end
                    vertex_q.push_back(tv);
                end
            end
        end
        end_burst();
        phases_run = 1;

        // random phases: fresh settings, then whole frames with random content
        rand_done = 0;
        while (rand_done < RAND_ITEMS) begin
            end_burst();
            wait_idle();
            k = $urandom_range(9);
            write_reg(REG_RANGE_MIN, (k == 0) ? 16'h8000 : 16'($urandom_range(65535)));
            write_reg(REG_RANGE_MAX, (k == 1) ? 16'h7FFF :
                      (k == 2) ? 16'(rng_min) : 16'($urandom_range(65535)));
            if ($urandom_range(3) != 0 && rng_min > rng_max) begin
                lo_v = rng_min;
                write_reg(REG_RANGE_MIN, 16'(rng_max));
                write_reg(REG_RANGE_MAX, 16'(lo_v));
            end
            write_reg(REG_VIEW_W, (k == 3) ? 16'd4095 : 16'($urandom_range(4095, 1)));
            write_reg(REG_VIEW_H, (k == 4) ? 16'd4095 : 16'($urandom_range(4095, 1)));
            write_reg(REG_STROKE_W, (k == 5) ? 16'd4095 : 16'($urandom_range(4095)));
            write_reg(REG_FILL_EN, 16'($urandom_range(1)));
            flen = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 2);
            write_reg(REG_COUNT, 16'(flen));
            phases_run++;
            repeat ($urandom_range(4, 1)) begin
                for (k = 0; k < flen; k++) begin
                    case ($urandom_range(3))
                        0: send_sample(16'($urandom_range(65535)), 1'b1);
                        1: send_sample(($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000, 1'b1);
                        default: send_sample(16'(rng_min + $urandom_range(
                            (rng_max > rng_min) ? 32'(rng_max - rng_min) : 0)), 1'b1);
                    endcase
                    rand_done++;
                end
            end
            // now and then leave a frame unfinished so the next settings meet it
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(3, 1)) begin
                    send_sample(16'($urandom_range(65535)), 1'b1);
                    rand_done++;
                end
            end
        end
        end_burst();

        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d samples over %0d register settings, %0d vertices checked",
                 samples_sent, phases_run, vertices_seen);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(2 * HALF_PERIOD * 1500000);
        $display("simulation failed");
        $finish;
    end

endmodule
